// ===== design/swmf_pkg.sv =====
// Shared types and constants for the sliding-window median block.
// No dependencies; imported by every block module but swmf_ram.
package swmf_pkg;

    localparam int WINDOW_DEPTH = 256;
    localparam int WEIGHT_W     = 64;
    localparam int WFILL_W      = 9;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [FILL_W-1:0]   fill_t;

    localparam fill_t DEPTH_FILL   = fill_t'(WINDOW_DEPTH);
    localparam fill_t FILL_ONE     = fill_t'(1);
    localparam fill_t INS_FULL_CNT = fill_t'(WINDOW_DEPTH - 1);
    localparam slot_t LAST_SLOT    = slot_t'(WINDOW_DEPTH - 1);
    localparam slot_t INS_FULL_PTR = slot_t'(WINDOW_DEPTH - 2);

    // One result word
    typedef struct packed {
        weight_t              median;
        weight_t              stake;
        logic [WFILL_W-1:0]   fill;
    } res_t;

endpackage

// ===== design/swmf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module swmf_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/swmf_cmp.sv =====
// Shared 64-bit magnitude comparator for the sequencer's compare steps.
// Depends on swmf_pkg.
module swmf_cmp
    import swmf_pkg::*;
(
    input  weight_t a,
    input  weight_t b,
    output logic    lt,
    output logic    eq
);

    assign lt = a < b;
    assign eq = a == b;

endmodule

// ===== design/swmf_seq.sv =====
// Sequencer: FIFO ring, sorted copy of the window, and median pick.
// Depends on swmf_pkg, swmf_ram and swmf_cmp.
module swmf_seq
    import swmf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  weight_t sample_weight,
    input  weight_t min_weight,
    output logic    res_valid,
    input  logic    res_ready,
    output res_t    res
);

    typedef enum logic [3:0] {
        S_IDLE, S_OLD, S_DROP, S_INS, S_PUT0, S_HI, S_LO, S_MID, S_OUT
    } state_t;

    state_t  state_reg,    state_next;
    fill_t   fill_reg,     fill_next;
    slot_t   oldest_reg,   oldest_next;
    weight_t x_reg,        x_next;
    weight_t old_reg,      old_next;
    weight_t t_reg,        t_next;
    weight_t med_reg,      med_next;
    slot_t   rd_ptr_reg,   rd_ptr_next;
    fill_t   rd_left_reg,  rd_left_next;
    logic    pend_reg,     pend_next;
    slot_t   pend_idx_reg, pend_idx_next;
    logic    found_reg,    found_next;

    logic    ring_we;
    slot_t   ring_waddr;
    weight_t ring_wdata;
    weight_t ring_rdata;
    logic    srt_we;
    slot_t   srt_waddr;
    weight_t srt_wdata;
    slot_t   srt_raddr;
    weight_t srt_rdata;
    weight_t cmp_a;
    weight_t cmp_b;
    logic    cmp_lt;
    logic    cmp_eq;

    logic [SLOT_W:0] tail_sum;
    slot_t           tail_slot;
    logic [FILL_W:0] rank_sum;
    slot_t           rank_slot;
    logic            is_full;
    logic            top_rank;
    logic            issue;

    swmf_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(WEIGHT_W)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (oldest_reg),
        .rdata (ring_rdata)
    );

    swmf_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(WEIGHT_W)) u_sorted (
        .clk   (clk),
        .we    (srt_we),
        .waddr (srt_waddr),
        .wdata (srt_wdata),
        .raddr (srt_raddr),
        .rdata (srt_rdata)
    );

    swmf_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt),
        .eq (cmp_eq)
    );

    assign is_full  = fill_reg == DEPTH_FILL;
    assign top_rank = fill_reg == FILL_ONE;
    assign issue    = rd_left_reg != '0;
    assign tail_sum = (SLOT_W+1)'(oldest_reg) + (SLOT_W+1)'(fill_reg);
    assign tail_slot = (tail_sum >= (SLOT_W+1)'(WINDOW_DEPTH))
                       ? SLOT_W'(tail_sum - (SLOT_W+1)'(WINDOW_DEPTH))
                       : SLOT_W'(tail_sum);
    // rank floor(n/2) with n = fill + 1
    assign rank_sum  = (FILL_W+1)'(fill_reg) + (FILL_W+1)'(1);
    assign rank_slot = SLOT_W'(rank_sum >> 1);

    assign in_ready   = state_reg == S_IDLE;
    assign res.median = med_reg;
    assign res.stake  = cmp_lt ? min_weight : med_reg;
    assign res.fill   = WFILL_W'(fill_reg);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        oldest_next   = oldest_reg;
        x_next        = x_reg;
        old_next      = old_reg;
        t_next        = t_reg;
        med_next      = med_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_left_next  = rd_left_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        ring_we       = 1'b0;
        ring_waddr    = tail_slot;
        ring_wdata    = sample_weight;
        srt_we        = 1'b0;
        srt_waddr     = pend_idx_reg;
        srt_wdata     = x_reg;
        srt_raddr     = rd_ptr_reg;
        cmp_a         = med_reg;
        cmp_b         = min_weight;
        res_valid     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next = sample_weight;
                    if (is_full)
                    begin
                        // ring read of the oldest slot is under way
                        state_next = S_OLD;
                    end
                    else
                    begin
                        ring_we      = 1'b1;
                        fill_next    = fill_reg + 1'b1;
                        rd_ptr_next  = slot_t'(fill_reg - 1'b1);
                        rd_left_next = fill_reg;
                        state_next   = (fill_reg == '0) ? S_PUT0 : S_INS;
                    end
                end
            end
            S_OLD:
            begin
                old_next   = ring_rdata;
                ring_we    = 1'b1;
                ring_waddr = oldest_reg;
                ring_wdata = x_reg;
                oldest_next = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
                rd_ptr_next  = '0;
                rd_left_next = DEPTH_FILL;
                found_next   = 1'b0;
                state_next   = S_DROP;
            end
            S_DROP:
            begin
                // ascending walk; close the gap left by the dropped sample
                pend_next     = issue;
                pend_idx_next = rd_ptr_reg;
                if (issue)
                begin
                    rd_left_next = rd_left_reg - 1'b1;
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                end
                cmp_a = srt_rdata;
                cmp_b = old_reg;
                if (pend_reg)
                begin
                    if (found_reg)
                    begin
                        srt_we    = 1'b1;
                        srt_waddr = slot_t'(pend_idx_reg - 1'b1);
                        srt_wdata = srt_rdata;
                    end
                    else if (cmp_eq)
                    begin
                        found_next = 1'b1;
                    end
                    if (pend_idx_reg == LAST_SLOT)
                    begin
                        pend_next    = 1'b0;
                        rd_ptr_next  = INS_FULL_PTR;
                        rd_left_next = INS_FULL_CNT;
                        state_next   = S_INS;
                    end
                end
            end
            S_INS:
            begin
                // descending walk; shift larger entries up until the slot opens
                pend_next     = issue;
                pend_idx_next = rd_ptr_reg;
                if (issue)
                begin
                    rd_left_next = rd_left_reg - 1'b1;
                    rd_ptr_next  = rd_ptr_reg - 1'b1;
                end
                cmp_a = x_reg;
                cmp_b = srt_rdata;
                if (pend_reg)
                begin
                    srt_we    = 1'b1;
                    srt_waddr = slot_t'(pend_idx_reg + 1'b1);
                    if (cmp_lt)
                    begin
                        srt_wdata = srt_rdata;
                        if (pend_idx_reg == '0)
                        begin
                            state_next = S_PUT0;
                        end
                    end
                    else
                    begin
                        srt_wdata  = x_reg;
                        state_next = S_HI;
                    end
                end
            end
            S_PUT0:
            begin
                srt_we     = 1'b1;
                srt_waddr  = '0;
                srt_wdata  = x_reg;
                state_next = S_HI;
            end
            S_HI:
            begin
                srt_raddr  = rank_slot;
                state_next = S_LO;
            end
            S_LO:
            begin
                srt_raddr = slot_t'(rank_slot - 1'b1);
                cmp_a     = min_weight;
                cmp_b     = srt_rdata;
                // no entry above the rank with a single sample
                t_next     = (top_rank || cmp_lt) ? min_weight : srt_rdata;
                state_next = S_MID;
            end
            S_MID:
            begin
                cmp_a      = srt_rdata;
                cmp_b      = t_reg;
                med_next   = cmp_lt ? t_reg : srt_rdata;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            oldest_reg  <= '0;
            rd_left_reg <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            oldest_reg  <= oldest_next;
            rd_left_reg <= rd_left_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        old_reg      <= old_next;
        t_reg        <= t_next;
        med_reg      <= med_next;
        rd_ptr_reg   <= rd_ptr_next;
        pend_idx_reg <= pend_idx_next;
    end

endmodule

// ===== design/sliding_window_median_floor.sv =====
// Top level of the sliding-window median with a configured floor.
// Depends on swmf_pkg and swmf_seq (which uses swmf_ram and swmf_cmp).
//
//   channel  | handshake            | word
//   ---------+----------------------+----------------------------------------
//   cfg      | cfg_valid/cfg_ready  | cfg_data: minimum_weight
//   in       | in_valid/in_ready    | sample_weight
//   out      | out_valid/out_ready  | median_weight, bounded_weight, window_fill
//
// While the window fills, a word needs only an insert walk over the sorted
// copy of the window; once it is full, that copy is walked once to drop the
// oldest sample and once to insert the new one, one entry per cycle through
// the sorted RAM's read port.
// Reset clears the counters and the floor; RAM contents need no clearing.
// in_ready is low while a word is at work. The result sits in an output
// register, so the next word is accepted while the previous result stalls.
module sliding_window_median_floor
    import swmf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  weight_t             cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  weight_t             sample_weight,
    output logic                out_valid,
    input  logic                out_ready,
    output weight_t             median_weight,
    output weight_t             bounded_weight,
    output logic [WFILL_W-1:0]  window_fill
);

    weight_t min_weight_reg;
    logic    out_valid_reg;
    res_t    out_data_reg;
    logic    res_valid;
    logic    res_ready;
    res_t    res;

    // Floor takes every write; the user must write only while idle, unchecked.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_weight_reg <= '0;
        end
        else if (cfg_valid)
        begin
            min_weight_reg <= cfg_data;
        end
    end

    swmf_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_weight (sample_weight),
        .min_weight    (min_weight_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // Output register: load when empty or draining this cycle, else hold.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign median_weight  = out_data_reg.median;
    assign bounded_weight = out_data_reg.stake;
    assign window_fill    = out_data_reg.fill;

endmodule

// ===== design/swmf_checker.sv =====
// Port-level checks for sliding_window_median_floor, bound to the top level.
// Depends on swmf_pkg.
module swmf_checker
    import swmf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input weight_t             median_weight,
    input weight_t             bounded_weight,
    input logic [WFILL_W-1:0]  window_fill
);

    // One word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is at work");

    // Bounded weight never falls below the median
    a_stake_ge_median: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bounded_weight >= median_weight)
        else $error("bounded_weight below median_weight");

    // Fill stays within the window
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (window_fill != '0) &&
                      (window_fill <= WFILL_W'(WINDOW_DEPTH)))
        else $error("window_fill out of range");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median_weight) &&
                                    $stable(bounded_weight) && $stable(window_fill))
        else $error("result changed while stalled");

endmodule

bind sliding_window_median_floor swmf_checker u_swmf_checker (.*);

// ===== sim/tb_top.sv =====
// Testbench for sliding_window_median_floor: random and directed sample words
// checked against an in-bench median predictor. Depends on swmf_pkg and the
// RTL of the block; nothing else.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swmf_pkg::*;

    localparam int      PHASE_SAMPLES = 75;      // random words per floor setting
    localparam int      RANDOM_PHASES = 6;       // about 450 random words in all
    localparam int      MAX_GAP       = 10;
    localparam int      REPORT_LIMIT  = 10;
    localparam int      DRAIN_CYCLES  = 2 * WINDOW_DEPTH + 20;
    localparam int      CYCLE_LIMIT   = 1_500_000;
    localparam weight_t WEIGHT_MAX    = '1;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    weight_t            cfg_data       = '0;
    logic               in_valid       = 1'b0;
    logic               in_ready;
    weight_t            sample_weight  = '0;
    logic               out_valid;
    logic               out_ready      = 1'b0;
    weight_t            median_weight;
    weight_t            bounded_weight;
    logic [WFILL_W-1:0] window_fill;

    sliding_window_median_floor dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_weight  (sample_weight),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .median_weight  (median_weight),
        .bounded_weight (bounded_weight),
        .window_fill    (window_fill)
    );

    always #5ns clk = ~clk;

    // Predictor state: the floor as last written, the window in arrival order
    // and the same samples kept in ascending order for the rank lookup.
    weight_t floor_weight = '0;
    weight_t window_fifo[$];
    weight_t window_sorted[$];

    res_t    median_expect[$];    // predicted result words, oldest first
    weight_t pending_samples[$];  // sample words not yet driven

    bit      no_idle        = 1'b0;
    int      in_gap         = 0;
    int      out_stall      = 0;
    bit      in_fire        = 1'b0;
    bit      out_fire       = 1'b0;
    int      mismatch_count = 0;
    int      cycle_count    = 0;

    // Advance the window by one sample and return the word the block owes.
    // The floor joins the sorted window at the first slot not below it, so the
    // element at rank floor(n/2) of the merged set comes straight from an index.
    function automatic res_t predict_median(weight_t w);
        res_t    r;
        weight_t gone;
        int      pos;
        int      below;
        int      rank;
        if (window_fifo.size() >= WINDOW_DEPTH)
        begin
            // full window: drop the oldest sample before storing the new one
            gone = window_fifo.pop_front();
            pos = 0;
            while (window_sorted[pos] != gone)
                pos++;
            window_sorted.delete(pos);
        end
        window_fifo = {window_fifo, w};
        pos = 0;
        while (pos < window_sorted.size() && window_sorted[pos] < w)
            pos++;
        window_sorted.insert(pos, w);

        below = 0;
        while (below < window_sorted.size() && window_sorted[below] < floor_weight)
            below++;
        rank = (window_sorted.size() + 1) / 2;
        if (rank < below)
            r.median = window_sorted[rank];
        else if (rank == below)
            r.median = floor_weight;
        else
            r.median = window_sorted[rank - 1];
        r.stake = (r.median > floor_weight) ? r.median : floor_weight;
        r.fill  = WFILL_W'(window_sorted.size());
        return r;
    endfunction

    // Mix of full-range values, small values that collide, values at and next
    // to the floor, and the two extremes.
    function automatic weight_t draw_sample();
        weight_t w;
        case ($urandom_range(0, 19)) inside
            [0:8]:   w = {$urandom, $urandom};
            [9:13]:  w = weight_t'($urandom_range(0, 24));
            [14:15]: w = floor_weight;
            16:      w = floor_weight + weight_t'(1);
            17:      w = floor_weight - weight_t'(1);
            18:      w = WEIGHT_MAX - weight_t'($urandom_range(0, 24));
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic weight_t draw_floor();
        weight_t w;
        case ($urandom_range(0, 4))
            0:       w = '0;
            1:       w = WEIGHT_MAX;
            2:       w = weight_t'($urandom_range(0, 24));
            3:       w = WEIGHT_MAX - weight_t'($urandom_range(0, 24));
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // Write the floor register; call only while the block is idle.
    task automatic write_floor(weight_t w);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        floor_weight = w;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued word is sent and every result word is back.
    task automatic wait_drained();
        @(posedge clk);
        while (pending_samples.size() != 0 || in_valid || median_expect.size() != 0)
            @(posedge clk);
    endtask

    // Input driver: drop valid once the word is taken, wait out the drawn gap,
    // then present the next pending sample. Valid is assigned once per edge.
    always @(negedge clk)
    begin
        logic    v;
        weight_t d;
        int      g;
        v = in_valid;
        d = sample_weight;
        g = in_gap;
        if (rst_n)
        begin
            if (in_valid && in_fire)
                v = 1'b0;
            if (!v)
            begin
                if (g > 0)
                    g--;
                else if (pending_samples.size() != 0)
                begin
                    d = pending_samples.pop_front();
                    v = 1'b1;
                    g = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                end
            end
        end
        in_valid      <= v;
        sample_weight <= d;
        in_gap        <= g;
    end

    // Output back-pressure: after each accepted result draw a stall, and count
    // it down only while a result is waiting so the stall really bites.
    always @(negedge clk)
    begin
        int s;
        s = out_stall;
        if (rst_n)
        begin
            if (out_fire)
                s = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            else if (s > 0 && out_valid)
                s--;
        end
        out_stall <= s;
        out_ready <= rst_n && (s == 0);
    end

    // Monitor: check the result word against the oldest prediction, then
    // predict for any sample word taken at this edge.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (median_expect.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected word: median %h bounded %h fill %0d",
                                 $time, median_weight, bounded_weight, window_fill);
                end
                else
                begin
                    want = median_expect.pop_front();
                    if (median_weight !== want.median || bounded_weight !== want.stake ||
                        window_fill !== want.fill)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: exp/got median %h/%h bounded %h/%h fill %0d/%0d",
                                     $time, want.median, median_weight, want.stake,
                                     bounded_weight, want.fill, window_fill);
                    end
                end
            end
            if (in_valid && in_ready)
                median_expect = {median_expect, predict_median(sample_weight)};
        end
        in_fire  <= in_valid && in_ready;
        out_fire <= out_valid && out_ready;
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Floor at zero: extremes of the sample, ties and alternating bits,
        // starting from an empty window.
        write_floor('0);
        pending_samples = '{'0, WEIGHT_MAX, weight_t'(1), WEIGHT_MAX - weight_t'(1),
                            64'h8000_0000_0000_0000, weight_t'(7), weight_t'(7),
                            weight_t'(7), 64'h5555_5555_5555_5555,
                            64'hAAAA_AAAA_AAAA_AAAA};
        wait_drained();

        // Floor at its maximum: it dominates the bound and ties with samples.
        write_floor(WEIGHT_MAX);
        pending_samples = '{weight_t'(3), WEIGHT_MAX, WEIGHT_MAX, '0, weight_t'(9)};
        wait_drained();

        // Floor in the middle, with samples equal to it and just around it.
        write_floor(64'h0000_0001_0000_0000);
        pending_samples = '{64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF,
                            64'h0000_0001_0000_0001, weight_t'(42), weight_t'(42)};
        wait_drained();

        // Random phases: the window fills during the first few and then stays
        // full, so most later words exercise the drop of the oldest sample.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_floor(draw_floor());
            no_idle = (ph == 1) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_SAMPLES; i++)
                pending_samples = {pending_samples, draw_sample()};
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && median_expect.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
design/swmf_pkg.sv
design/swmf_ram.sv
design/swmf_cmp.sv
design/swmf_seq.sv
design/sliding_window_median_floor.sv
design/swmf_checker.sv
sim/tb_top.sv
